FILE: src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared types and constants for the allocator and its table memory.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ArenaBytes  = 65536;
	localparam int HeaderBytes = 16;
	localparam int MaxBlocks   = 256;

	localparam int IdxW  = $clog2(MaxBlocks);
	localparam int CntW  = IdxW + 1;
	localparam int SizeW = $clog2(ArenaBytes) + 1;
	localparam int PosW  = SizeW + 1;
	localparam int EntW  = SizeW + 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD     = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_DOUBLE  = 3'd4;

	typedef struct packed {
		logic        op;
		logic [15:0] req_size;
		logic [15:0] data_offset;
	} req_t;

	typedef struct packed {
		logic [15:0] granted_offset;
		logic [2:0]  status;
	} rsp_t;

endpackage

FILE: src/ffha_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Synchronous write and registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Address-ordered block table in one RAM, scanned and shifted by a sequencer.
// ----------------------------------------------------------------------------
// A zero-size or null request is answered straight from idle; any other request
// reads and checks table entries in address order, a free then checks its next
// and previous neighbors, and a split or merge shifts the entries behind it,
// in two passes after a double merge.
// Throughput: one request at a time; busy is high until done pulses, and the
// receiver cannot stall a result. Reset clears state, count, heap end and response, not the table RAM.
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CHK, S_NXT, S_NCHK, S_PRV, S_PCHK,
		S_SHR, S_SHW, S_SHL, S_SLW, S_FIN
	} state_t;

	state_t          state_q;
	req_t            req_q;
	logic [CntW-1:0] count_q;
	logic [PosW-1:0] heap_q;
	logic [CntW-1:0] idx_q;
	logic [CntW-1:0] ptr_q;
	logic [PosW-1:0] pos_q;
	logic [SizeW-1:0] size_q;
	logic            ins_q;
	logic            drop_q;
	logic [EntW-1:0] ins_ent_q;
	logic [CntW-1:0] hold_q;
	logic            dlast_q;

	logic            we;
	logic [IdxW-1:0] waddr, raddr;
	logic [EntW-1:0] wdata, rdata;
	logic            rd_free;
	logic [SizeW-1:0] rd_size;

	ffha_ram #(.Width(EntW), .Depth(MaxBlocks)) u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign rd_free = rdata[EntW-1];
	assign rd_size = rdata[SizeW-1:0];
	assign busy    = (state_q != S_IDLE);

	logic [PosW-1:0] need;
	assign need = PosW'(req_q.req_size) + PosW'(HeaderBytes);

	// Read address and write port are chosen per state.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IdxW-1:0];
		wdata = '0;
		raddr = ptr_q[IdxW-1:0];
		case (state_q)
			S_CHK: begin
				if (req_q.op == OP_ALLOC && ptr_q < count_q && rd_free
						&& rd_size >= SizeW'(req_q.req_size)) begin
					we    = 1'b1;
					waddr = ptr_q[IdxW-1:0];
					if (PosW'(rd_size) >= need + PosW'(1) && count_q < CntW'(MaxBlocks))
						wdata = {1'b0, SizeW'(req_q.req_size)};
					else
						wdata = {1'b0, rd_size};
				end else if (req_q.op == OP_ALLOC && ptr_q >= count_q
						&& count_q < CntW'(MaxBlocks)
						&& need <= PosW'(ArenaBytes) - heap_q) begin
					we    = 1'b1;
					waddr = count_q[IdxW-1:0];
					wdata = {1'b0, SizeW'(req_q.req_size)};
				end
			end
			S_SHW: begin
				// Insert shifting walks down; write held entry one above.
				we    = 1'b1;
				waddr = IdxW'(ptr_q + CntW'(1));
				wdata = rdata;
			end
			S_SLW: begin
				we    = 1'b1;
				waddr = IdxW'(ptr_q - CntW'(1));
				wdata = rdata;
			end
			S_FIN: begin
				if (ins_q) begin
					we    = 1'b1;
					waddr = IdxW'(idx_q + CntW'(1));
					wdata = ins_ent_q;
				end else if (drop_q) begin
					we    = 1'b0;
				end else if (req_q.op == OP_FREE) begin
					we    = 1'b1;
					wdata = {1'b1, size_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			heap_q  <= '0;
			done    <= 1'b0;
			rsp     <= '0;
			ptr_q   <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			ins_q   <= 1'b0;
			drop_q  <= 1'b0;
			dlast_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						ptr_q <= '0;
						pos_q <= '0;
						ins_q <= 1'b0;
						drop_q <= 1'b0;
						dlast_q <= 1'b0;
						if ((req.op == OP_ALLOC && req.req_size == '0)
								|| (req.op == OP_FREE && req.data_offset == '0)) begin
							rsp     <= '{granted_offset: '0, status: ST_BAD};
							done    <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (req_q.op == OP_ALLOC) begin
						if (ptr_q >= count_q) begin
							if (count_q < CntW'(MaxBlocks)
									&& need <= PosW'(ArenaBytes) - heap_q) begin
								rsp <= '{granted_offset: 16'(heap_q + PosW'(HeaderBytes)),
									status: ST_OK};
								heap_q  <= heap_q + need;
								count_q <= count_q + CntW'(1);
							end else begin
								rsp <= '{granted_offset: '0, status: ST_NOSPACE};
							end
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else if (rd_free && rd_size >= SizeW'(req_q.req_size)) begin
							rsp <= '{granted_offset: 16'(pos_q + PosW'(HeaderBytes)),
								status: ST_OK};
							if (PosW'(rd_size) >= need + PosW'(1)
									&& count_q < CntW'(MaxBlocks)) begin
								ins_q     <= 1'b1;
								ins_ent_q <= {1'b1, SizeW'(PosW'(rd_size) - need)};
								idx_q     <= ptr_q;
								if (count_q == ptr_q + CntW'(1)) begin
									state_q <= S_FIN;
								end else begin
									ptr_q   <= count_q - CntW'(1);
									state_q <= S_SHR;
								end
							end else begin
								done    <= 1'b1;
								state_q <= S_IDLE;
							end
						end else begin
							pos_q   <= pos_q + PosW'(HeaderBytes) + PosW'(rd_size);
							ptr_q   <= ptr_q + CntW'(1);
							state_q <= S_RD;
						end
					end else begin
						if (ptr_q >= count_q) begin
							rsp     <= '{granted_offset: '0, status: ST_UNKNOWN};
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else if (pos_q + PosW'(HeaderBytes) == PosW'(req_q.data_offset)) begin
							if (rd_free) begin
								rsp     <= '{granted_offset: '0, status: ST_DOUBLE};
								done    <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								rsp    <= '{granted_offset: '0, status: ST_OK};
								idx_q  <= ptr_q;
								size_q <= rd_size;
								ptr_q  <= ptr_q + CntW'(1);
								state_q <= S_NXT;
							end
						end else begin
							pos_q   <= pos_q + PosW'(HeaderBytes) + PosW'(rd_size);
							ptr_q   <= ptr_q + CntW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_NXT: state_q <= S_NCHK;
				S_NCHK: begin
					// Merge with a free next neighbor: drop entry idx+1.
					if (ptr_q < count_q && rd_free) begin
						size_q  <= size_q + SizeW'(HeaderBytes) + rd_size;
						drop_q  <= 1'b1;
					end
					if (idx_q != '0) begin
						ptr_q   <= idx_q - CntW'(1);
						state_q <= S_PRV;
					end else begin
						state_q <= S_PCHK;
						ptr_q   <= idx_q;
					end
				end
				S_PRV: state_q <= S_PCHK;
				S_PCHK: begin
					// Resolve merges into one final entry at idx, then close the gap.
					logic [CntW-1:0] cnt;
					logic [CntW-1:0] gap;
					logic [SizeW-1:0] fsz;
					logic            pm;
					pm  = (idx_q != '0) && rd_free;
					fsz = pm ? rd_size + SizeW'(HeaderBytes) + size_q : size_q;
					cnt = count_q - (drop_q ? CntW'(1) : '0) - (pm ? CntW'(1) : '0);
					gap = CntW'(drop_q) + CntW'(pm);
					if (pm) idx_q <= idx_q - CntW'(1);
					size_q <= fsz;
					if ((pm ? idx_q - CntW'(1) : idx_q) + CntW'(1) == cnt) begin
						// Final block is last: release it and all after is gone.
						heap_q  <= (PosW'(HeaderBytes) + PosW'(fsz) <= heap_q)
							? heap_q - PosW'(HeaderBytes) - PosW'(fsz) : '0;
						count_q <= cnt - CntW'(1);
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						count_q <= cnt;
						if (gap != '0) begin
							drop_q  <= 1'b1;
							dlast_q <= (gap == CntW'(2));
							ptr_q   <= idx_q + CntW'(1) + (drop_q ? CntW'(1) : '0);
							hold_q  <= count_q;
							state_q <= S_SHL;
						end else begin
							drop_q  <= 1'b0;
							state_q <= S_FIN;
						end
					end
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					if (ptr_q == idx_q + CntW'(1)) begin
						state_q <= S_FIN;
					end else begin
						ptr_q   <= ptr_q - CntW'(1);
						state_q <= S_SHR;
					end
				end
				S_SHL: state_q <= S_SLW;
				S_SLW: begin
					// ptr walks the entries past the gap; hold_q keeps old count.
					if (ptr_q + CntW'(1) >= hold_q) begin
						if (dlast_q) begin
							dlast_q <= 1'b0;
							ptr_q   <= idx_q + CntW'(2);
							hold_q  <= count_q + CntW'(1);
							state_q <= S_SHL;
						end else begin
							drop_q  <= 1'b0;
							state_q <= S_FIN;
						end
					end else begin
						ptr_q   <= ptr_q + CntW'(1);
						state_q <= S_SHL;
					end
				end
				S_FIN: begin
					if (ins_q) count_q <= count_q + CntW'(1);
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntW'(MaxBlocks))
		else $error("block count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) heap_q <= PosW'(ArenaBytes))
		else $error("heap end beyond arena");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while a request is still in work");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("request lost");

endmodule

FILE: dv/tb_first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests, predicts each response from a local
// model of the block table and heap end, and compares every response.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	localparam int CycleLimit = 10000000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	first_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	// Local copy of the allocator state.
	int unsigned heap_sizes[$];
	bit          heap_free[$];
	int unsigned heap_top;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   errors;
	int   cycles;
	int   sender_idle_pct;
	bit   hold_sender;
	int   granted_list[$];
	int   n_alloc, n_free, n_split, n_merge;

	function automatic rsp_t predict_alloc(int unsigned size);
		rsp_t r;
		int unsigned pos;
		int unsigned sz;
		r.granted_offset = '0;
		r.status = ST_OK;
		pos = 0;
		if (size == 0) begin
			r.status = ST_BAD;
			return r;
		end
		for (int i = 0; i < heap_sizes.size(); i++) begin
			sz = heap_sizes[i];
			if (heap_free[i] && sz >= size) begin
				if (sz >= size + HeaderBytes + 1 && heap_sizes.size() < MaxBlocks) begin
					heap_sizes.insert(i + 1, sz - size - HeaderBytes);
					heap_free.insert(i + 1, 1'b1);
					heap_sizes[i] = size;
					n_split++;
				end
				heap_free[i] = 1'b0;
				r.granted_offset = 16'(pos + HeaderBytes);
				return r;
			end
			pos += HeaderBytes + sz;
		end
		if (heap_sizes.size() >= MaxBlocks ||
				HeaderBytes + size > ArenaBytes - heap_top) begin
			r.status = ST_NOSPACE;
			return r;
		end
		heap_sizes.push_back(size);
		heap_free.push_back(1'b0);
		r.granted_offset = 16'(heap_top + HeaderBytes);
		heap_top += HeaderBytes + size;
		return r;
	endfunction

	function automatic rsp_t predict_free(int unsigned off);
		rsp_t r;
		int unsigned pos;
		int idx;
		int unsigned span;
		r.granted_offset = '0;
		r.status = ST_OK;
		if (off == 0) begin
			r.status = ST_BAD;
			return r;
		end
		pos = 0;
		idx = -1;
		for (int i = 0; i < heap_sizes.size(); i++) begin
			if (pos + HeaderBytes == off) begin
				idx = i;
				break;
			end
			pos += HeaderBytes + heap_sizes[i];
		end
		if (idx < 0) begin
			r.status = ST_UNKNOWN;
			return r;
		end
		if (heap_free[idx]) begin
			r.status = ST_DOUBLE;
			return r;
		end
		heap_free[idx] = 1'b1;
		if (idx + 1 < heap_sizes.size() && heap_free[idx + 1]) begin
			heap_sizes[idx] += HeaderBytes + heap_sizes[idx + 1];
			heap_sizes.delete(idx + 1);
			heap_free.delete(idx + 1);
			n_merge++;
		end
		if (idx > 0 && heap_free[idx - 1]) begin
			heap_sizes[idx - 1] += HeaderBytes + heap_sizes[idx];
			heap_sizes.delete(idx);
			heap_free.delete(idx);
			idx--;
			n_merge++;
		end
		if (idx + 1 == heap_sizes.size()) begin
			span = HeaderBytes + heap_sizes[idx];
			heap_top = (span <= heap_top) ? heap_top - span : 0;
			heap_sizes.delete(idx);
			heap_free.delete(idx);
		end
		return r;
	endfunction

	function automatic rsp_t predict_rsp(req_t q);
		if (q.op == OP_ALLOC) begin
			n_alloc++;
			return predict_alloc(q.req_size);
		end
		n_free++;
		return predict_free(q.data_offset);
	endfunction

	function automatic req_t make_req(logic op, int unsigned size, int unsigned off);
		req_t q;
		q.op = op;
		q.req_size = 16'(size);
		q.data_offset = 16'(off);
		return q;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Driver: one transfer per accepted start; the prediction is made at acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				expected_rsps.push_back(predict_rsp(req));
				void'(pending_reqs.pop_front());
			end
			if (start && busy) begin
				// Keep presenting the same item until it is taken.
			end else if (pending_reqs.size() != 0 && !hold_sender &&
					$urandom_range(99) >= sender_idle_pct) begin
				start <= 1'b1;
				req <= pending_reqs[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: each strobed response is matched against the oldest prediction.
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected response: granted_offset %0d status %0d",
					rsp.granted_offset, rsp.status);
				errors++;
			end else begin
				exp_r = expected_rsps.pop_front();
				if (rsp.granted_offset !== exp_r.granted_offset) begin
					$error("granted_offset: expected %0d actual %0d",
						exp_r.granted_offset, rsp.granted_offset);
					errors++;
				end
				if (rsp.status !== exp_r.status) begin
					$error("status: expected %0d actual %0d", exp_r.status, rsp.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_first_fit_heap_allocator: done, errors");
			$finish;
		end
	end

	task automatic drain();
		while (pending_reqs.size() != 0 || start || busy || expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	// Random request with a bias toward well-formed traffic: mostly frees of live
	// grants and modest allocations, with some noise offsets and huge sizes.
	task automatic queue_random(int count);
		int unsigned sel;
		int unsigned off;
		int k;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			if (sel < 45) begin
				pending_reqs.push_back(make_req(OP_ALLOC,
					($urandom_range(9) == 0) ? $urandom_range(65535) :
					$urandom_range(1, 600), $urandom));
			end else if (sel < 50) begin
				pending_reqs.push_back(make_req(OP_ALLOC, $urandom_range(1, 3), $urandom));
			end else if (sel < 88 && granted_list.size() != 0) begin
				k = $urandom_range(granted_list.size() - 1);
				off = granted_list[k];
				if ($urandom_range(9) != 0)
					granted_list.delete(k);
				pending_reqs.push_back(make_req(OP_FREE, $urandom, off));
			end else begin
				pending_reqs.push_back(make_req(OP_FREE, $urandom,
					($urandom_range(3) == 0) ? 0 : $urandom));
			end
		end
	endtask

	// Offsets of live grants are learned from the monitor side of the stream.
	always @(posedge clk) begin
		if (arst_n && done && rsp.status == ST_OK && rsp.granted_offset != 0)
			granted_list.push_back(rsp.granted_offset);
	end

	initial begin
		errors = 0;
		cycles = 0;
		heap_top = 0;
		sender_idle_pct = 7;
		hold_sender = 1'b0;
		n_alloc = 0; n_free = 0; n_split = 0; n_merge = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: bad requests, unknown and double frees, split, merges.
		pending_reqs.push_back(make_req(OP_ALLOC, 0, 16'hFFFF));
		pending_reqs.push_back(make_req(OP_FREE, 16'hFFFF, 0));
		pending_reqs.push_back(make_req(OP_FREE, 0, 16'hFFFF));
		pending_reqs.push_back(make_req(OP_ALLOC, 100, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 1, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 200, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 8, 0));
		pending_reqs.push_back(make_req(OP_FREE, 0, 16));
		pending_reqs.push_back(make_req(OP_FREE, 0, 16));
		pending_reqs.push_back(make_req(OP_FREE, 0, 17));
		pending_reqs.push_back(make_req(OP_ALLOC, 50, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 34, 0));
		pending_reqs.push_back(make_req(OP_FREE, 0, 149));
		pending_reqs.push_back(make_req(OP_FREE, 0, 16));
		pending_reqs.push_back(make_req(OP_FREE, 0, 132));
		pending_reqs.push_back(make_req(OP_FREE, 0, 165));
		pending_reqs.push_back(make_req(OP_ALLOC, 16'hFFFF, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 65500, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 65520, 0));
		pending_reqs.push_back(make_req(OP_FREE, 0, 16));
		drain();

		// Fill the table with single bytes, then exercise a full table.
		for (int i = 0; i < MaxBlocks + 2; i++)
			pending_reqs.push_back(make_req(OP_ALLOC, (i == 3) ? 200 : 1, 0));
		pending_reqs.push_back(make_req(OP_FREE, 0, 3 * 17 + 16));
		pending_reqs.push_back(make_req(OP_ALLOC, 10, 0));
		drain();
		for (int i = 0; i < MaxBlocks; i++)
			pending_reqs.push_back(make_req(OP_FREE, 0, 16 + 17 * i +
				((i > 3) ? 199 : 0)));
		drain();
		granted_list.delete();

		queue_random(205);
		drain();
		sender_idle_pct = 74;
		queue_random(205);
		repeat (400) @(posedge clk);
		// The sender holds off until every outstanding response has come back.
		hold_sender = 1'b1;
		while (start || busy || expected_rsps.size() != 0)
			@(posedge clk);
		hold_sender = 1'b0;
		drain();
		sender_idle_pct = 0;
		queue_random(204);
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d allocates and %0d frees, %0d splits and %0d merges",
			n_alloc, n_free, n_split, n_merge);
		if (errors == 0)
			$display("tb_first_fit_heap_allocator: done, clean");
		else
			$display("tb_first_fit_heap_allocator: done, errors");
		$finish;
	end
endmodule
